@@ rtl/core/mfps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfps_pkg
// Shared types and constants for the maximum falling path sum block.
// ----------------------------------------------------------------------------
package mfps_pkg;

  localparam int SUM_BITS       = 22;
  localparam int CFG_BITS       = 7;
  localparam int CFG_RESET      = 64;
  localparam int MAX_SIZE_DEF   = 64;
  localparam int VALUE_BITS_DEF = 16;
  localparam int PADDR_BITS     = 3;
  localparam int PDATA_BITS     = 32;

  // register index is paddr[2]
  localparam logic REG_MATRIX_SIZE = 1'b0;

  typedef logic signed [SUM_BITS-1:0] sum_t;

  // which neighbors of the previous row take part
  typedef struct packed {
    logic first_row;
    logic use_left;
    logic use_right;
  } nbr_t;

endpackage

@@ rtl/core/mfps_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfps_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/mfps_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfps_cell
// Adds one cell value to the best valid neighbor sum, saturating.
// ----------------------------------------------------------------------------
module mfps_cell #(
  parameter int VALUE_BITS = 16
) (
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  mfps_pkg::sum_t               left_i,
  input  mfps_pkg::sum_t               here_i,
  input  mfps_pkg::sum_t               right_i,
  input  mfps_pkg::nbr_t               nbr_i,
  output mfps_pkg::sum_t               sum_o
);

  import mfps_pkg::*;

  localparam int WW = ((VALUE_BITS > SUM_BITS) ? VALUE_BITS : SUM_BITS) + 1;
  localparam logic signed [WW-1:0] WMAX =
    {{(WW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [WW-1:0] WMIN =
    {{(WW-SUM_BITS+1){1'b1}}, {(SUM_BITS-1){1'b0}}};

  sum_t                 best;
  logic signed [WW-1:0] wide;

  always_comb begin
    best = here_i;
    if (nbr_i.use_left && (left_i > best)) begin
      best = left_i;
    end
    if (nbr_i.use_right && (right_i > best)) begin
      best = right_i;
    end
    if (nbr_i.first_row) begin
      best = '0;
    end
    wide = WW'(value_i) + WW'(best);
    if (wide > WMAX) begin
      sum_o = WMAX[SUM_BITS-1:0];
    end else if (wide < WMIN) begin
      sum_o = WMIN[SUM_BITS-1:0];
    end else begin
      sum_o = wide[SUM_BITS-1:0];
    end
  end

endmodule

@@ rtl/core/max_falling_path_sum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_falling_path_sum
// Streams an n x n matrix row by row and returns its maximum falling path sum.
// ----------------------------------------------------------------------------
// Throughput: one cell per cycle while in_stall_o is low, with at most one RAM read and one write per cell.
// Latency: the result is registered and valid the cycle after the last cell.
// Reset: counts cleared, matrix_size = 64; row RAM needs no clearing pass,
// row 0 writes every entry before any read data is used.
module max_falling_path_sum #(
  parameter int MAX_SIZE   = mfps_pkg::MAX_SIZE_DEF,
  parameter int VALUE_BITS = mfps_pkg::VALUE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [VALUE_BITS-1:0]           cell_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output mfps_pkg::sum_t                         path_sum_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mfps_pkg::PADDR_BITS-1:0]        paddr,
  input  logic [mfps_pkg::PDATA_BITS-1:0]        pwdata,
  output logic [mfps_pkg::PDATA_BITS-1:0]        prdata,
  output logic                                   pready
);

  import mfps_pkg::*;

  localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int NW = $clog2(MAX_SIZE + 1);
  localparam int CW = NW + 1;
  localparam int EW = ((NW > CFG_BITS) ? NW : CFG_BITS) + 1;
  localparam int RST_SIZE = (MAX_SIZE < CFG_RESET) ? MAX_SIZE : CFG_RESET;

  logic [CFG_BITS-1:0] msize_q;
  logic [NW-1:0]       size_q, size_d;
  logic [AW-1:0]       col_q, row_q;
  logic                out_valid_q;
  sum_t                out_q, left_q, rgt_q, head0_q, head1_q, best_q;

  logic                cfg_wr, in_acc, res_done;
  logic [CW-1:0]       col_p1, col_p2, row_p1;
  logic                last_col, last_row, has_right, rd_en;
  logic [CFG_BITS-1:0] wval;
  sum_t                ram_rdata, here, right, sum, best_nxt;
  nbr_t                nbr;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);
  assign prdata     = (paddr[2] == REG_MATRIX_SIZE) ? PDATA_BITS'(msize_q) : '0;
  assign wval       = pwdata[CFG_BITS-1:0];

  always_comb begin
    if (wval == '0) begin
      size_d = NW'(1);
    end else if (EW'(wval) > EW'(MAX_SIZE)) begin
      size_d = NW'(MAX_SIZE);
    end else begin
      size_d = NW'(wval);
    end
  end

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign path_sum_o  = out_q;

  assign col_p1    = CW'(col_q) + CW'(1);
  assign col_p2    = CW'(col_q) + CW'(2);
  assign row_p1    = CW'(row_q) + CW'(1);
  assign last_col  = (col_p1 == CW'(size_q));
  assign last_row  = (row_p1 == CW'(size_q));
  assign has_right = (col_p1 < CW'(size_q));
  assign rd_en     = in_acc && (col_p2 < CW'(size_q));
  assign res_done  = in_acc && !cfg_wr && last_col && last_row;

  // columns 0 and 1 of the previous row live in head registers
  assign here  = (col_q == '0) ? head0_q : rgt_q;
  assign right = (col_q == '0) ? head1_q : ram_rdata;

  assign nbr.first_row = (row_q == '0);
  assign nbr.use_left  = (col_q != '0);
  assign nbr.use_right = has_right;

  mfps_cell #(
    .VALUE_BITS(VALUE_BITS)
  ) u_cell (
    .value_i (cell_value_i),
    .left_i  (left_q),
    .here_i  (here),
    .right_i (right),
    .nbr_i   (nbr),
    .sum_o   (sum)
  );

  mfps_ram #(
    .WIDTH(SUM_BITS),
    .DEPTH(MAX_SIZE)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (col_q),
    .wdata_i (sum),
    .re_i    (rd_en),
    .raddr_i (col_p2[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign best_nxt = ((col_q == '0) || (sum > best_q)) ? sum : best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msize_q     <= CFG_BITS'(CFG_RESET);
      size_q      <= NW'(RST_SIZE);
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_done) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        msize_q <= wval;
        size_q  <= size_d;
        col_q   <= '0;
        row_q   <= '0;
      end else if (in_acc) begin
        if (!last_col) begin
          col_q <= col_p1[AW-1:0];
        end else begin
          col_q <= '0;
          if (!last_row) begin
            row_q <= row_p1[AW-1:0];
          end else begin
            row_q <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !cfg_wr) begin
      left_q <= here;
      rgt_q  <= right;
      if (col_q == '0) begin
        head0_q <= sum;
      end
      if (col_q == AW'(1)) begin
        head1_q <= sum;
      end
      if (last_row) begin
        best_q <= best_nxt;
      end
      if (last_col && last_row) begin
        out_q <= best_nxt;
      end
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for max_falling_path_sum.
// Streams square matrices of signed cells through the block and checks every
// path sum against a cycle-free model of the row-sum recurrence kept here.
// The matrix side is set over the register port between phases. Sides 1..6
// carry most of the traffic. A few larger sides, a partial matrix at the
// largest side, out-of-range and zero sides, writes to an unmapped register
// and interrupted matrices cover the rest. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb;

  import mfps_pkg::*;

  localparam int     VALUE_BITS    = VALUE_BITS_DEF;
  localparam int     MAX_SIDE      = MAX_SIZE_DEF;
  localparam longint SUM_HI        = (longint'(1) <<< (SUM_BITS - 1)) - 1;
  localparam longint SUM_LO        = -(longint'(1) <<< (SUM_BITS - 1));
  localparam logic   REG_UNUSED    = 1'b1;
  localparam int     RANDOM_CELLS  = 1000;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     CYCLE_LIMIT   = 500000;

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_stall_o;
  logic signed [VALUE_BITS-1:0]  cell_value_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i  = 1'b0;
  sum_t                          path_sum_o;
  logic                          psel         = 1'b0;
  logic                          penable      = 1'b0;
  logic                          pwrite       = 1'b0;
  logic [PADDR_BITS-1:0]         paddr        = '0;
  logic [PDATA_BITS-1:0]         pwdata       = '0;
  logic [PDATA_BITS-1:0]         prdata;
  logic                          pready;

  max_falling_path_sum dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cell_value_i (cell_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .path_sum_o   (path_sum_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic [CFG_BITS-1:0]          side_reg;
  sum_t                         prev_row [MAX_SIDE];
  sum_t                         left_old;
  int                           col_idx;
  int                           row_idx;
  sum_t                         best_sum;

  logic signed [VALUE_BITS-1:0] cells_to_send [$];
  sum_t                         sums_due [$];
  sum_t                         sum_want;
  int                           send_gap_pct   = 0;
  int                           recv_stall_pct = 0;
  int                           hold_left      = 0;
  int                           error_count    = 0;
  int                           cells_sent     = 0;
  int                           cycle_count    = 0;

  function automatic int live_side();
    if (side_reg == 0) return 1;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return int'(side_reg);
  endfunction

  function automatic void restart_matrix();
    left_old = '0;
    col_idx  = 0;
    row_idx  = 0;
    best_sum = '0;
  endfunction

  function automatic void absorb_cell(logic signed [VALUE_BITS-1:0] v);
    int     n;
    int     c;
    int     r;
    longint best;
    longint total;
    sum_t   here;
    n    = live_side();
    c    = col_idx;
    r    = row_idx;
    here = prev_row[c];
    if (r == 0) begin
      total = v;
    end else begin
      best = here;
      if (c > 0 && left_old > best) best = left_old;
      if (c + 1 < n && prev_row[c+1] > best) best = prev_row[c+1];
      total = v + best;
      if (total > SUM_HI) total = SUM_HI;
      else if (total < SUM_LO) total = SUM_LO;
    end
    left_old    = here;
    prev_row[c] = sum_t'(total);
    if (r == n - 1 && (c == 0 || total > best_sum)) best_sum = sum_t'(total);
    if (c + 1 < n) begin
      col_idx = c + 1;
    end else begin
      col_idx  = 0;
      left_old = '0;
      if (r + 1 < n) begin
        row_idx = r + 1;
      end else begin
        sums_due.push_back(best_sum);
        restart_matrix();
      end
    end
  endfunction

  function automatic void flag_mismatch(string what, longint want, longint got);
    error_count++;
    if (error_count <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_cell();
    case ($urandom_range(9))
      0: return {1'b1, {(VALUE_BITS-1){1'b0}}};
      1: return {1'b0, {(VALUE_BITS-1){1'b1}}};
      default: return VALUE_BITS'($urandom());
    endcase
  endfunction

  // cell driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) absorb_cell(cell_value_i);
      if (!in_valid_i || !in_stall_o) begin
        if (cells_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          cell_value_i <= cells_to_send.pop_front();
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result-side stall, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // path sum monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sums_due.size() == 0) begin
        flag_mismatch("path_sum with none pending", 0, path_sum_o);
      end else begin
        sum_want = sums_due.pop_front();
        if (path_sum_o !== sum_want) flag_mismatch("path_sum", sum_want, path_sum_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic apb_write(input logic reg_idx, input logic [PDATA_BITS-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (reg_idx == REG_MATRIX_SIZE) begin
      side_reg = data[CFG_BITS-1:0];
      restart_matrix();
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apb_check_side();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_MATRIX_SIZE, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== PDATA_BITS'(side_reg)) flag_mismatch("matrix_size readback", side_reg, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (cells_to_send.size() != 0 || in_valid_i || sums_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_gap_pct   = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    int n;
    int count;
    int side_pick;
    foreach (prev_row[i]) prev_row[i] = '0;
    side_reg = CFG_BITS'(CFG_RESET);
    restart_matrix();
    set_idling(33, 84);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    apb_check_side();

    // partial matrix at the reset side, then a side change must restart it
    cells_to_send.push_back(16'sh8000);
    cells_to_send.push_back(16'sh7fff);
    cells_to_send.push_back(16'sh0001);
    wait_idle();

    // side 0 behaves as side 1: every cell is a whole matrix
    apb_write(REG_MATRIX_SIZE, 32'h0);
    apb_check_side();
    cells_to_send.push_back(16'sh8000);
    cells_to_send.push_back(16'sh7fff);
    cells_to_send.push_back(16'sh0000);
    cells_to_send.push_back(16'shffff);
    wait_idle();

    // 2 x 2, then a broken matrix cut off by the next side write
    apb_write(REG_MATRIX_SIZE, 32'h2);
    apb_check_side();
    cells_to_send.push_back(16'sh7fff);
    cells_to_send.push_back(16'sh8000);
    cells_to_send.push_back(16'sh8000);
    cells_to_send.push_back(16'sh7fff);
    cells_to_send.push_back(16'shaaaa);
    cells_to_send.push_back(16'sh5555);
    wait_idle();

    // 3 x 3 with an unmapped register write in the middle; must not restart
    apb_write(REG_MATRIX_SIZE, 32'hffff_ff83);
    apb_check_side();
    cells_to_send.push_back(16'sh7fff);
    cells_to_send.push_back(16'shffff);
    cells_to_send.push_back(16'sh8000);
    cells_to_send.push_back(16'sh0000);
    cells_to_send.push_back(16'sh7fff);
    wait_idle();
    apb_write(REG_UNUSED, 32'h0000_0005);
    cells_to_send.push_back(16'sh8000);
    cells_to_send.push_back(16'sh8000);
    cells_to_send.push_back(16'sh7fff);
    cells_to_send.push_back(16'sh0001);
    wait_idle();

    // out-of-range side behaves as the largest one: no early path sum
    apb_write(REG_MATRIX_SIZE, ($urandom() & 32'hffff_ff80) | 32'h7f);
    apb_check_side();
    repeat (3 * MAX_SIDE + 5) cells_to_send.push_back(pick_cell());
    wait_idle();
    apb_write(REG_MATRIX_SIZE, 32'h4);
    apb_check_side();

    while (cells_sent < RANDOM_CELLS) begin
      if (cells_sent < RANDOM_CELLS / 3) set_idling(33, 84);
      else if (cells_sent < 2 * RANDOM_CELLS / 3) set_idling(84, 33);
      else set_idling(0, 0);
      if ($urandom_range(7) == 0) begin
        apb_write(REG_UNUSED, $urandom());
      end else begin
        case ($urandom_range(19))
          0, 1:    side_pick = 0;
          2, 3, 4: side_pick = $urandom_range(7, 16);
          default: side_pick = $urandom_range(1, 6);
        endcase
        apb_write(REG_MATRIX_SIZE, ($urandom() & 32'hffff_ff80) | side_pick);
        apb_check_side();
      end
      n     = live_side();
      count = ((n <= 6) ? $urandom_range(1, 4) : 1) * n * n;
      if ($urandom_range(7) == 0 && n > 1) count += $urandom_range(1, n * n - 1);
      repeat (count) cells_to_send.push_back(pick_cell());
      cells_sent += count;
      wait_idle();
    end

    // long hold-off on the result side while cells keep coming
    set_idling(0, 0);
    apb_write(REG_MATRIX_SIZE, 32'h1);
    apb_check_side();
    hold_left = HOLD_CYCLES;
    repeat (400) cells_to_send.push_back(pick_cell());
    wait_idle();

    if (error_count == 0 && sums_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mfps_pkg.sv
rtl/core/mfps_ram.sv
rtl/core/mfps_cell.sv
rtl/core/max_falling_path_sum.sv
bench/tb.sv
